### src/frac_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package frac_pkg;

  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned MAG_WIDTH  = DATA_WIDTH;
  localparam int unsigned CNT_WIDTH  = $clog2(MAG_WIDTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD,
    ST_DIV_START,
    ST_DIV,
    ST_DONE
  } frac_state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic gcd_step;
    logic div_init;
    logic div_step;
    logic finish;
  } frac_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic den_zero;
    logic gcd_done;
    logic div_last;
  } frac_stat_t;

endpackage
`default_nettype wire

### src/frac_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module frac_datapath (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire  frac_pkg::frac_cmd_t             cmd_i,
  output frac_pkg::frac_stat_t                  stat_o,
  input  wire  signed [frac_pkg::DATA_WIDTH-1:0] numerator_i,
  input  wire  signed [frac_pkg::DATA_WIDTH-1:0] denominator_i,
  output logic signed [frac_pkg::DATA_WIDTH-1:0] numerator_o,
  output logic        [frac_pkg::DATA_WIDTH-2:0] denominator_o,
  output logic                                  status_o
);
  import frac_pkg::*;

  logic [MAG_WIDTH-1:0] an_q, ad_q, ga_q, gb_q;
  logic [MAG_WIDTH-1:0] an_d, ad_d, ga_d, gb_d;
  logic [CNT_WIDTH-1:0] gk_q, gk_d;
  logic                 neg_q, neg_d, zero_q, zero_d;
  // shared restoring divider, divides both magnitudes by the gcd together
  logic [MAG_WIDTH-1:0] qn_q, qn_d, qd_q, qd_d, rn_q, rn_d, rd_q, rd_d;
  logic [CNT_WIDTH-1:0] cnt_q, cnt_d;
  logic [MAG_WIDTH-1:0] mag_n, mag_d;
  logic [MAG_WIDTH:0]   trn, trd;

  // magnitudes of the operands
  assign mag_n = numerator_i[DATA_WIDTH-1] ? (~numerator_i + 1'b1) : numerator_i;
  assign mag_d = denominator_i[DATA_WIDTH-1] ? (~denominator_i + 1'b1) : denominator_i;

  // trial subtractions
  assign trn = {rn_q, qn_q[MAG_WIDTH-1]} - {1'b0, ga_q};
  assign trd = {rd_q, qd_q[MAG_WIDTH-1]} - {1'b0, ga_q};

  assign stat_o.den_zero = zero_q;
  assign stat_o.gcd_done = (ga_q == '0) || (gb_q == '0);
  assign stat_o.div_last = (cnt_q == CNT_WIDTH'(1));

  always_comb begin
    an_d = an_q; ad_d = ad_q; ga_d = ga_q; gb_d = gb_q; gk_d = gk_q;
    neg_d = neg_q; zero_d = zero_q;
    qn_d = qn_q; qd_d = qd_q; rn_d = rn_q; rd_d = rd_q; cnt_d = cnt_q;
    if (cmd_i.load) begin
      an_d   = mag_n;
      ad_d   = mag_d;
      ga_d   = mag_n;
      gb_d   = mag_d;
      gk_d   = '0;
      neg_d  = numerator_i[DATA_WIDTH-1] ^ denominator_i[DATA_WIDTH-1];
      zero_d = (mag_d == '0);
    end
    // binary gcd: strip common twos, halve even operands, halve odd differences
    if (cmd_i.gcd_step && ga_q != '0 && gb_q != '0) begin
      if (!ga_q[0] && !gb_q[0]) begin
        ga_d = ga_q >> 1;
        gb_d = gb_q >> 1;
        gk_d = gk_q + 1'b1;
      end else if (!ga_q[0]) begin
        ga_d = ga_q >> 1;
      end else if (!gb_q[0]) begin
        gb_d = gb_q >> 1;
      end else if (ga_q >= gb_q) begin
        ga_d = (ga_q - gb_q) >> 1;
      end else begin
        gb_d = (gb_q - ga_q) >> 1;
      end
    end
    if (cmd_i.div_init) begin
      ga_d  = (ga_q | gb_q) << gk_q;
      qn_d  = an_q;
      qd_d  = ad_q;
      rn_d  = '0;
      rd_d  = '0;
      cnt_d = CNT_WIDTH'(MAG_WIDTH);
    end
    if (cmd_i.div_step) begin
      if (!trn[MAG_WIDTH]) rn_d = trn[MAG_WIDTH-1:0];
      else                 rn_d = {rn_q[MAG_WIDTH-2:0], qn_q[MAG_WIDTH-1]};
      if (!trd[MAG_WIDTH]) rd_d = trd[MAG_WIDTH-1:0];
      else                 rd_d = {rd_q[MAG_WIDTH-2:0], qd_q[MAG_WIDTH-1]};
      qn_d  = {qn_q[MAG_WIDTH-2:0], ~trn[MAG_WIDTH]};
      qd_d  = {qd_q[MAG_WIDTH-2:0], ~trd[MAG_WIDTH]};
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    an_q <= an_d; ad_q <= ad_d; ga_q <= ga_d; gb_q <= gb_d; gk_q <= gk_d;
    neg_q <= neg_d; zero_q <= zero_d;
    qn_q <= qn_d; qd_q <= qd_d; rn_q <= rn_d; rd_q <= rd_d; cnt_q <= cnt_d;
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      numerator_o   <= '0;
      denominator_o <= '0;
      status_o      <= 1'b0;
    end else if (cmd_i.finish) begin
      if (zero_q) begin
        numerator_o   <= '0;
        denominator_o <= '0;
        status_o      <= 1'b1;
      end else begin
        numerator_o   <= (neg_q && qn_q != '0) ? (~qn_q + 1'b1) : qn_q;
        denominator_o <= qd_q[DATA_WIDTH-2:0];
        status_o      <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

### src/frac_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module frac_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output frac_pkg::frac_cmd_t  cmd_o,
  input  wire frac_pkg::frac_stat_t stat_i
);
  import frac_pkg::*;

  frac_state_e state_q, state_d;
  logic        ovalid_q, ovalid_d;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:      if (in_valid_i) state_d = ST_GCD;
      ST_GCD:       if (stat_i.den_zero) state_d = ST_DONE;
                    else if (stat_i.gcd_done) state_d = ST_DIV_START;
      ST_DIV_START: state_d = ST_DIV;
      ST_DIV:       if (stat_i.div_last) state_d = ST_DONE;
      ST_DONE:      if (!ovalid_q || out_ready_i) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    case (state_q)
      ST_IDLE:      begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_GCD:       cmd_o.gcd_step = 1'b1;
      ST_DIV_START: cmd_o.div_init = 1'b1;
      ST_DIV:       cmd_o.div_step = 1'b1;
      ST_DONE:      cmd_o.finish = !ovalid_q || out_ready_i;
      default:      cmd_o = '0;
    endcase
  end

  // output valid flag
  always_comb begin
    ovalid_d = ovalid_q;
    if (out_ready_i) ovalid_d = 1'b0;
    if (cmd_o.finish) ovalid_d = 1'b1;
  end
  assign out_valid_o = ovalid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end
endmodule
`default_nettype wire

### src/fraction_reduce.sv
`timescale 1ns / 1ps
`default_nettype none
// Reduces a signed fraction to lowest terms with a positive denominator;
// a zero denominator gives status 1 and zero values. One item at a time:
// the operands are loaded, the gcd is found by a binary gcd loop, one step
// a cycle, then handed off to a shared restoring divider that gives both
// quotients, and a finish step writes the result; a zero denominator goes
// straight from the gcd state to finish. The result sits in an output
// register, so the next item may be accepted while it waits to be taken.
module fraction_reduce (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   in_valid_i,
  output logic                                  in_ready_o,
  input  wire  signed [frac_pkg::DATA_WIDTH-1:0] numerator_in_i,
  input  wire  signed [frac_pkg::DATA_WIDTH-1:0] denominator_in_i,
  output logic                                  out_valid_o,
  input  wire                                   out_ready_i,
  output logic signed [frac_pkg::DATA_WIDTH-1:0] numerator_out_o,
  output logic        [frac_pkg::DATA_WIDTH-2:0] denominator_out_o,
  output logic                                  status_o
);
  import frac_pkg::*;

  frac_cmd_t  cmd;
  frac_stat_t stat;

  frac_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .cmd_o(cmd), .stat_i(stat)
  );

  frac_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .numerator_i(numerator_in_i), .denominator_i(denominator_in_i),
    .numerator_o(numerator_out_o), .denominator_o(denominator_out_o),
    .status_o
  );
endmodule
`default_nettype wire
